// File: hw/rtl/ascfc_pkg.sv
// Shared constants, types and helpers for the ASCII sensor frame checker.
package ascfc_pkg;

    localparam int BUFFER_BYTES_DEF = 50;
    localparam int SUM_SPAN         = 10;

    localparam int POS_HUNDREDS = 0;
    localparam int POS_POINT    = 1;
    localparam int POS_TENS     = 2;
    localparam int POS_UNITS    = 3;
    localparam int POS_CHK_HI   = 11;
    localparam int POS_CHK_LO   = 12;

    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] POINT_CHAR = 8'h2E;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] HEX_BAD    = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_BLANK = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] sum;
        logic [7:0] hundreds;
        logic [7:0] point;
        logic [7:0] tens;
        logic [7:0] units;
        logic [7:0] chk_hi;
        logic [7:0] chk_lo;
    } t_frame;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'd48;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'd55;
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/ascfc_decode.sv
// Checksum, decimal point and digit decode of one completed frame.
module ascfc_decode (
    input  ascfc_pkg::t_frame  i_frame,
    output logic [15:0]        o_concentration,
    output ascfc_pkg::t_status o_status
);

    logic [7:0]  expect_sum;
    logic [12:0] got_sum;
    logic [15:0] val;
    logic        blank;

    always_comb begin
        expect_sum = 8'(8'd0 - i_frame.sum);
        got_sum    = {1'b0, ascfc_pkg::hex_value(i_frame.chk_hi), 4'd0}
                   + 13'(ascfc_pkg::hex_value(i_frame.chk_lo));
        blank      = (i_frame.hundreds == ascfc_pkg::SPACE_CHAR)
                  || (i_frame.tens == ascfc_pkg::SPACE_CHAR)
                  || (i_frame.units == ascfc_pkg::SPACE_CHAR);
        val = 16'((16'(i_frame.hundreds) - 16'(ascfc_pkg::ZERO_CHAR)) * 16'd100)
            + 16'((16'(i_frame.tens) - 16'(ascfc_pkg::ZERO_CHAR)) * 16'd10)
            + (16'(i_frame.units) - 16'(ascfc_pkg::ZERO_CHAR));

        o_concentration = 16'd0;
        if ((got_sum != 13'(expect_sum)) || (i_frame.point != ascfc_pkg::POINT_CHAR)) begin
            o_status = ascfc_pkg::ST_BAD;
        end else if (blank) begin
            o_status = ascfc_pkg::ST_BLANK;
        end else begin
            o_status        = ascfc_pkg::ST_OK;
            o_concentration = val;
        end
    end

endmodule

// File: hw/rtl/ascii_sensor_frame_checker_top.sv
// Top level of the ASCII sensor frame checker.
//
//  channel | direction | signals                       | payload
//  --------+-----------+-------------------------------+--------------------------------
//  rx      | in        | i_valid, o_stall              | i_rx_byte
//  result  | out       | o_valid, i_stall              | o_concentration, o_status
//
// One byte per cycle while no result waits under i_stall: an input register, then
// the combinational frame update and decode into the result register.
// Only an LF byte writes a result; other bytes only update the frame state.
// Reset is synchronous, active low, and clears position, sum and kept chars.
// The input register holds only while a result waits under i_stall.
module ascii_sensor_frame_checker_top #(
    parameter int BUFFER_BYTES = ascfc_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_concentration,
    output logic [1:0]  o_status
);

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic [POS_W-1:0]   r_pos,   n_pos;
    ascfc_pkg::t_frame  r_frame, n_frame, upd_frame;
    logic               r_out_valid;
    logic [15:0]        r_conc;
    ascfc_pkg::t_status r_status;
    logic [15:0]        dec_conc;
    ascfc_pkg::t_status dec_status;
    logic               adv;
    logic               work;
    logic               is_lf;

    assign adv     = !(r_out_valid && i_stall);
    assign work    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;
    assign is_lf   = (r_in_byte == ascfc_pkg::LINE_FEED);

    always_comb begin
        upd_frame = r_frame;
        if (r_pos < POS_W'(BUFFER_BYTES)) begin
            if (r_pos < POS_W'(ascfc_pkg::SUM_SPAN)) begin
                upd_frame.sum = r_frame.sum + r_in_byte;
            end
            if (r_pos == POS_W'(ascfc_pkg::POS_HUNDREDS)) upd_frame.hundreds = r_in_byte;
            if (r_pos == POS_W'(ascfc_pkg::POS_POINT))    upd_frame.point    = r_in_byte;
            if (r_pos == POS_W'(ascfc_pkg::POS_TENS))     upd_frame.tens     = r_in_byte;
            if (r_pos == POS_W'(ascfc_pkg::POS_UNITS))    upd_frame.units    = r_in_byte;
            if (r_pos == POS_W'(ascfc_pkg::POS_CHK_HI))   upd_frame.chk_hi   = r_in_byte;
            if (r_pos == POS_W'(ascfc_pkg::POS_CHK_LO))   upd_frame.chk_lo   = r_in_byte;
        end
    end

    always_comb begin
        n_frame = upd_frame;
        n_pos   = r_pos;
        if (is_lf) begin
            n_frame.sum = 8'd0;
            n_pos       = '0;
        end else if (r_pos < POS_W'(BUFFER_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    ascfc_decode u_decode (
        .i_frame         (upd_frame),
        .o_concentration (dec_conc),
        .o_status        (dec_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_frame     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= work && is_lf;
            end
            if (work) begin
                r_pos   <= n_pos;
                r_frame <= n_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (work && is_lf) begin
            r_conc   <= dec_conc;
            r_status <= dec_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_concentration = r_conc;
    assign o_status        = r_status;

endmodule

// File: hw/rtl/ascfc_checker.sv
// Port-level assertions for the ASCII sensor frame checker, bound to the top level.
module ascfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_concentration,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_concentration) && $stable(o_status))
        else $error("result changed while stalled");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ascfc_pkg::ST_OK) |-> o_concentration == 16'd0)
        else $error("nonzero concentration on a failed frame");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ascfc_pkg::ST_OK) || (o_status == ascfc_pkg::ST_BAD)
                 || (o_status == ascfc_pkg::ST_BLANK))
        else $error("undefined status code");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a transaction two cycles before");

endmodule

bind ascii_sensor_frame_checker_top ascfc_checker u_ascfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_concentration (o_concentration),
    .o_status        (o_status)
);

// File: sim/testbench.sv
// Testbench for the ASCII sensor frame checker: byte stream in, checked readings out.
`timescale 1ns / 100ps

module testbench;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         TARGET_BYTES = 650;
    localparam logic [7:0] TAB_CHAR     = 8'h09;
    localparam logic [7:0] CR_CHAR      = 8'h0D;

    typedef struct {
        logic [15:0]        conc;
        ascfc_pkg::t_status st;
    } t_reading;

    typedef struct {
        logic [7:0]         b;
        bit                 typed;
        logic [15:0]        conc;
        ascfc_pkg::t_status st;
    } t_script_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_concentration;
    logic [1:0]  o_status;

    // frame predictor state
    logic [5:0] fr_pos        = '0;
    logic [7:0] fr_sum        = '0;
    logic [7:0] kept_hundreds = '0;
    logic [7:0] kept_point    = '0;
    logic [7:0] kept_tens     = '0;
    logic [7:0] kept_units    = '0;
    logic [7:0] kept_chk_hi   = '0;
    logic [7:0] kept_chk_lo   = '0;

    t_reading readings_due [$];
    t_reading head;
    int       mismatches  = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       bytes_used  = 0;
    logic [7:0] stall_phase = '0;

    ascii_sensor_frame_checker_top #(
        .BUFFER_BYTES(ascfc_pkg::BUFFER_BYTES_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_concentration(o_concentration),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end
        if (c >= "A" && c <= "F") begin
            return c - 8'd55;
        end
        return ascfc_pkg::HEX_BAD;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        c = {4'd0, n};
        return (n < 4'd10) ? ascfc_pkg::ZERO_CHAR + c : "A" - 8'd10 + c;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == ascfc_pkg::LINE_FEED);
        return c;
    endfunction

    function automatic logic [7:0] digit_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return ascfc_pkg::SPACE_CHAR;
        end
        if (pick == 1) begin
            return any_but_lf();
        end
        return ascfc_pkg::ZERO_CHAR + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] invalid_hex();
        logic [7:0] c;
        do begin
            c = any_but_lf();
        end while (hex_digit_value(c) != ascfc_pkg::HEX_BAD);
        return c;
    endfunction

    // Advances the frame state by one byte; on LF yields the decoded reading.
    function automatic void decode_frame_byte(input logic [7:0] b, output bit done,
                                              output t_reading r);
        logic [12:0] got;
        logic [7:0]  want;
        done   = 1'b0;
        r.conc = '0;
        r.st   = ascfc_pkg::ST_OK;
        if (fr_pos < ascfc_pkg::BUFFER_BYTES_DEF) begin
            if (fr_pos < ascfc_pkg::SUM_SPAN) begin
                fr_sum = fr_sum + b;
            end
            case (fr_pos)
                ascfc_pkg::POS_HUNDREDS: kept_hundreds = b;
                ascfc_pkg::POS_POINT:    kept_point    = b;
                ascfc_pkg::POS_TENS:     kept_tens     = b;
                ascfc_pkg::POS_UNITS:    kept_units    = b;
                ascfc_pkg::POS_CHK_HI:   kept_chk_hi   = b;
                ascfc_pkg::POS_CHK_LO:   kept_chk_lo   = b;
                default: ;
            endcase
        end
        if (b != ascfc_pkg::LINE_FEED) begin
            if (fr_pos < ascfc_pkg::BUFFER_BYTES_DEF) begin
                fr_pos = fr_pos + 6'd1;
            end
        end else begin
            done = 1'b1;
            want = 8'd0 - fr_sum;
            got  = {5'd0, hex_digit_value(kept_chk_hi)} * 13'd16
                 + {5'd0, hex_digit_value(kept_chk_lo)};
            if ({5'd0, want} != got || kept_point != ascfc_pkg::POINT_CHAR) begin
                r.st = ascfc_pkg::ST_BAD;
            end else if (kept_hundreds == ascfc_pkg::SPACE_CHAR ||
                         kept_tens == ascfc_pkg::SPACE_CHAR ||
                         kept_units == ascfc_pkg::SPACE_CHAR) begin
                r.st = ascfc_pkg::ST_BLANK;
            end else begin
                r.conc = ({8'd0, kept_hundreds} - {8'd0, ascfc_pkg::ZERO_CHAR}) * 16'd100
                       + ({8'd0, kept_tens} - {8'd0, ascfc_pkg::ZERO_CHAR}) * 16'd10
                       + ({8'd0, kept_units} - {8'd0, ascfc_pkg::ZERO_CHAR});
            end
            fr_pos = '0;
            fr_sum = '0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    // Drives one transaction, returns at the edge that accepts it.
    task automatic put_byte(input logic [7:0] b, input bit typed,
                            input logic [15:0] t_conc, input ascfc_pkg::t_status t_st);
        int       gap;
        bit       taken;
        bit       done;
        t_reading r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        if (fr_pos < ascfc_pkg::BUFFER_BYTES_DEF || b == ascfc_pkg::LINE_FEED) begin
            bytes_used++;
        end
        decode_frame_byte(b, done, r);
        if (done) begin
            if (typed) begin
                r.conc = t_conc;
                r.st   = t_st;
            end
            readings_due.push_back(r);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] data [ascfc_pkg::SUM_SPAN];
        logic [7:0] frame_q [$];
        logic [7:0] part_sum;
        logic [7:0] want;
        int         kind;
        int         sub;
        int         len;
        int         k;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            for (k = 0; k < ascfc_pkg::SUM_SPAN; k++) begin
                data[k] = any_but_lf();
            end
            data[ascfc_pkg::POS_HUNDREDS] = digit_char();
            data[ascfc_pkg::POS_TENS]     = digit_char();
            data[ascfc_pkg::POS_UNITS]    = digit_char();
            if ($urandom_range(0, 9) != 0) begin
                data[ascfc_pkg::POS_POINT] = ascfc_pkg::POINT_CHAR;
            end
            sub = $urandom_range(0, 9);
            if (sub == 9) begin
                // '0' plus a bad low char decodes to 0xFF: force the sum to 1
                do begin
                    for (k = ascfc_pkg::POS_UNITS + 1; k < ascfc_pkg::SUM_SPAN - 1; k++) begin
                        data[k] = any_but_lf();
                    end
                    part_sum = '0;
                    for (k = 0; k < ascfc_pkg::SUM_SPAN - 1; k++) begin
                        part_sum += data[k];
                    end
                    data[ascfc_pkg::SUM_SPAN - 1] = 8'd1 - part_sum;
                end while (data[ascfc_pkg::SUM_SPAN - 1] == ascfc_pkg::LINE_FEED);
            end
            part_sum = '0;
            for (k = 0; k < ascfc_pkg::SUM_SPAN; k++) begin
                part_sum += data[k];
                frame_q.push_back(data[k]);
            end
            want = 8'd0 - part_sum;
            frame_q.push_back(TAB_CHAR);
            if (sub == 9) begin
                frame_q.push_back(ascfc_pkg::ZERO_CHAR);
                frame_q.push_back(invalid_hex());
            end else if (sub == 8) begin
                frame_q.push_back(any_but_lf());
                frame_q.push_back(any_but_lf());
            end else begin
                frame_q.push_back(hex_char(want[7:4]));
                frame_q.push_back(hex_char(want[3:0]));
            end
            frame_q.push_back(CR_CHAR);
            frame_q.push_back(ascfc_pkg::LINE_FEED);
        end else if (kind < 85) begin
            len = (kind < 75) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            repeat (len) frame_q.push_back(any_but_lf());
            frame_q.push_back(ascfc_pkg::LINE_FEED);
        end else begin
            repeat ($urandom_range(1, 16)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        foreach (frame_q[i]) begin
            put_byte(frame_q[i], 1'b0, 16'd0, ascfc_pkg::ST_OK);
        end
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= ($urandom_range(0, 99) < 30);
            2'd2: i_stall <= ($urandom_range(0, 99) < 75);
            default: i_stall <= (stall_phase[1:0] == 2'd0);
        endcase
    end

    // outputs and i_stall settle between edges; a transaction seen here lands next edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("unexpected reading %0d status %0d",
                                          o_concentration, o_status));
            end else begin
                head = readings_due.pop_front();
                if (o_concentration !== head.conc) begin
                    report_mismatch($sformatf("concentration %0d, expected %0d",
                                              o_concentration, head.conc));
                end
                if (o_status !== head.st) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, head.st));
                end
            end
        end
    end

    initial begin
        t_script_row script [$];
        script.push_back('{ascfc_pkg::LINE_FEED,  1'b1, 16'd0,   ascfc_pkg::ST_BAD});
        script.push_back('{"4",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::POINT_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{"0",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{"0",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{TAB_CHAR,              1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{"7",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{"E",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{CR_CHAR,               1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::LINE_FEED,  1'b1, 16'd400, ascfc_pkg::ST_OK});
        // short frame, checksum chars kept from before, blank hundreds
        script.push_back('{ascfc_pkg::SPACE_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::POINT_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{"*",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::LINE_FEED,  1'b1, 16'd0,   ascfc_pkg::ST_BLANK});
        // non-digit chars in the reading, LF kept as the tens char
        script.push_back('{"J",                   1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::POINT_CHAR, 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::LINE_FEED,  1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{8'hFF,                 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{8'h00,                 1'b0, 16'd0,   ascfc_pkg::ST_OK});
        script.push_back('{ascfc_pkg::LINE_FEED,  1'b1, 16'd0,   ascfc_pkg::ST_BAD});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (script[i]) begin
            put_byte(script[i].b, script[i].typed, script[i].conc, script[i].st);
        end
        while (bytes_used < TARGET_BYTES) begin
            send_random_frame();
        end
        i_valid <= 1'b0;
        while (readings_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
